FILE: rtl/glef_pkg.sv
// Shared types and constants of the gray Laplacian edge filter.
// No dependencies; imported by the filter, the port checker and the testbench.
package glef_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PIX_W       = 8;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 10;
   localparam int DIM_W       = 11;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;
   localparam int GSUM_W      = 16;

   // luma weights, sum to 256
   localparam logic [GSUM_W-1:0] GRAY_WEIGHT_R = 16'd77;
   localparam logic [GSUM_W-1:0] GRAY_WEIGHT_G = 16'd150;
   localparam logic [GSUM_W-1:0] GRAY_WEIGHT_B = 16'd29;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic [COL_W-1:0] pixel_column;
      logic [ROW_W-1:0] pixel_row;
      logic             last_of_run;
      logic             end_of_frame;
   } result_type;

   // pixel in the compute stage
   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic [PIX_W-1:0] gray;
      logic             has_upper;
      logic             last_row;
      logic             row_end;
      logic             interior;
      logic             la_self;
   } stage_type;

   // zero counts as one, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_v);
      logic [DIM_W-1:0] r;
      begin
         if (v == '0) begin
            r = DIM_W'(1);
         end else if (v > max_v) begin
            r = max_v;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

endpackage

FILE: rtl/glef_ram.sv
// Generic single-port-write, single-port-read RAM with registered read (read-first).
// No dependencies.
module glef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gray_laplacian_edge_filter.sv
// Gray conversion and 3x3 four-neighbour Laplacian over a raster RGB stream.
// The request that completes a result passes through the compute stage into the queue
// (pixel (x,y-1) is completed by request (x,y); last-row pixels by their own request).
// Throughput: one request per cycle while the queue has room; on the last row two
// results per request, so the result side paces requests through the 8-entry queue.
// Reset (synchronous): counters, queue and stage valid clear, sizes return to 1024;
// line stores are not cleared (first row of each frame fills them).
module gray_laplacian_edge_filter import glef_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // edge_value [7:0], pixel_column [17:8],
                                              // pixel_row [27:18], zero [31:28]
   output logic                  rsp_tlast,   // last_of_run
   output logic                  rsp_tuser,   // end_of_frame
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [DIM_W-1:0]      csr_wr_data
);

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // compute stage
   logic             b_valid_ff;
   stage_type        b_ff, b_in;
   logic             fwd_old_ff, fwd_old_in;
   logic [PIX_W-1:0] fwd_old_data_ff, fwd_old_data_in;
   logic             fwd_new_ff, fwd_new_in;
   logic [PIX_W-1:0] fwd_new_data_ff, fwd_new_data_in;

   // sliding window on the newer row: centre and left neighbour
   logic [PIX_W-1:0] center_ff, center_in;
   logic [PIX_W-1:0] left_ff;

   // result queue
   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // ---------------------------------------------------------------- issue side
   logic             accept;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;
   logic             row_end, last_row;
   logic [COL_W-1:0] la_addr;
   logic [GSUM_W-1:0] gray_sum;
   logic [QCNT_W:0]  need;

   always_comb begin
      w_eff  = clamp_dim(width_ff, DIM_W'(MAX_WIDTH));
      h_eff  = clamp_dim(height_ff, DIM_W'(MAX_HEIGHT));
      w_last = COL_W'(w_eff - DIM_W'(1));
      h_last = ROW_W'(h_eff - DIM_W'(1));

      row_end  = col_ff >= w_last;
      last_row = row_ff >= h_last;

      // look one column ahead on the newer row; at row end wrap to column 0
      la_addr = row_end ? '0 : col_ff + COL_W'(1);

      gray_sum = {8'd0, req_tdata[7:0]}   * GRAY_WEIGHT_R
               + {8'd0, req_tdata[15:8]}  * GRAY_WEIGHT_G
               + {8'd0, req_tdata[23:16]} * GRAY_WEIGHT_B;

      // room for this request and the one in the compute stage, two results each
      need       = {1'b0, count_ff} + {{(QCNT_W-1){1'b0}}, b_valid_ff, 1'b0} + (QCNT_W+1)'(2);
      req_tready = need <= (QCNT_W+1)'(QUEUE_DEPTH);
      accept     = req_tvalid && req_tready;

      b_in.x         = col_ff;
      b_in.y         = row_ff;
      b_in.gray      = gray_sum[GSUM_W-1:GSUM_W-PIX_W];
      b_in.has_upper = row_ff != '0;
      b_in.last_row  = last_row;
      b_in.row_end   = row_end;
      b_in.interior  = (row_ff >= ROW_W'(2)) && (col_ff != '0) && !row_end;
      b_in.la_self   = la_addr == col_ff;

      // the compute stage writes both stores this cycle; RAM reads return old data
      fwd_old_in      = b_valid_ff && (b_ff.x == col_ff);
      fwd_old_data_in = center_ff;
      fwd_new_in      = b_valid_ff && (b_ff.x == la_addr);
      fwd_new_data_in = b_ff.gray;

      if (row_end) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   // configuration
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wr_data;
            REG_IMAGE_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- line stores
   logic [PIX_W-1:0] older_rd, newer_rd;

   glef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_ff.x),
      .wr_data (center_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   glef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_ff.x),
      .wr_data (b_ff.gray),
      .rd_en   (accept),
      .rd_addr (la_addr),
      .rd_data (newer_rd)
   );

   // ---------------------------------------------------------------- compute stage
   logic [PIX_W-1:0]  up_pix, right_pix, lap_val, value0;
   logic [COL_W-1:0]  nsum, four_c, diff;
   result_type        res0, res1, first_res;
   logic              push_two;
   logic [1:0]        n_push;
   logic              pop;

   always_comb begin
      up_pix    = fwd_old_ff ? fwd_old_data_ff : older_rd;
      right_pix = fwd_new_ff ? fwd_new_data_ff : newer_rd;

      nsum   = {2'b00, up_pix} + {2'b00, b_ff.gray} + {2'b00, left_ff} + {2'b00, right_pix};
      four_c = {center_ff, 2'b00};
      diff   = four_c - nsum;
      if (nsum >= four_c) begin
         lap_val = '0;
      end else if (diff > COL_W'(255)) begin
         lap_val = '1;
      end else begin
         lap_val = diff[PIX_W-1:0];
      end
      value0 = b_ff.interior ? lap_val : center_ff;

      res0.edge_value   = value0;
      res0.pixel_column = b_ff.x;
      res0.pixel_row    = b_ff.y - ROW_W'(1);
      res0.last_of_run  = !b_ff.last_row;
      res0.end_of_frame = 1'b0;

      // last row passes through together with its own request
      res1.edge_value   = b_ff.gray;
      res1.pixel_column = b_ff.x;
      res1.pixel_row    = b_ff.y;
      res1.last_of_run  = 1'b1;
      res1.end_of_frame = b_ff.row_end;

      first_res = b_ff.has_upper ? res0 : res1;
      push_two  = b_valid_ff && b_ff.has_upper && b_ff.last_row;
      n_push    = b_valid_ff ? 2'({1'b0, b_ff.has_upper} + {1'b0, b_ff.last_row}) : 2'd0;

      // with width one the lookahead is this very pixel
      center_in = b_ff.la_self ? b_ff.gray : right_pix;

      pop       = rsp_tvalid && rsp_tready;
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   // ---------------------------------------------------------------- output
   result_type head;

   always_comb begin
      head       = queue_ff[rd_ptr_ff];
      rsp_tvalid = count_ff != '0;
      rsp_tdata  = {4'b0000, head.pixel_row, head.pixel_column, head.edge_value};
      rsp_tlast  = head.last_of_run;
      rsp_tuser  = head.end_of_frame;
   end

   // ---------------------------------------------------------------- clocked
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(MAX_WIDTH);
         height_ff  <= DIM_W'(MAX_HEIGHT);
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         b_valid_ff <= accept;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ff            <= b_in;
         fwd_old_ff      <= fwd_old_in;
         fwd_old_data_ff <= fwd_old_data_in;
         fwd_new_ff      <= fwd_new_in;
         fwd_new_data_ff <= fwd_new_data_in;
      end
      if (b_valid_ff) begin
         center_ff <= center_in;
         left_ff   <= center_ff;
         if (n_push != 2'd0) begin
            queue_ff[wr_ptr_ff] <= first_res;
         end
         if (push_two) begin
            queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
         end
      end
   end

endmodule

FILE: rtl/glef_checker.sv
// Port-level checker for the gray Laplacian edge filter, bound to the top level.
// Depends on glef_pkg and gray_laplacian_edge_filter.
module glef_checker import glef_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   // queue is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // end of frame is always the final result of its request
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end of frame without last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         ($stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("response payload changed while stalled");

endmodule

bind gray_laplacian_edge_filter glef_checker u_glef_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb_gray_laplacian_edge_filter.sv
// Self-checking testbench for gray_laplacian_edge_filter: RGB requests in, edge results out.
// Depends on glef_pkg and the filter RTL; results are checked against an in-bench predictor.
`timescale 1ns / 100ps

module tb_gray_laplacian_edge_filter;
   import glef_pkg::*;

   // bit positions inside rsp_tdata
   localparam int COL_LSB = PIX_W;
   localparam int ROW_LSB = PIX_W + COL_W;
   localparam int PAD_LSB = PIX_W + COL_W + ROW_W;

   localparam int SETTLE_CYCLES  = 8;     // settle time for the compute stage and queue, with margin
   localparam int HOLD_CYCLES    = 300;   // long result-side stall
   localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
   localparam int RANDOM_ITEMS   = 500;
   localparam int MAX_REPORTS    = 40;

   // DUT ports; the driven inputs are known from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   csr_index_type         csr_index   = REG_IMAGE_WIDTH;
   logic [DIM_W-1:0]      csr_wr_data = '0;

   // predictor state: our own copy of the sizes, line stores and raster position
   logic [DIM_W-1:0]      frame_width  = DIM_W'(MAX_WIDTH);
   logic [DIM_W-1:0]      frame_height = DIM_W'(MAX_HEIGHT);
   logic [PIX_W-1:0]      line_older [MAX_WIDTH];
   logic [PIX_W-1:0]      line_newer [MAX_WIDTH];
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   // edge results still owed by the block, oldest first
   result_type            pending_results [$];

   int                    error_count     = 0;
   int                    quiet_cycles    = 0;
   int                    rsp_hold_cycles = 0;
   bit                    steady_flow     = 1'b0;

   gray_laplacian_edge_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: one accepted pixel in, zero to two expected results queued.
   // ---------------------------------------------------------------------
   function automatic void predict_pixel(input logic [PIX_W-1:0] red, green, blue);
      int unsigned w, h, x, y, gray, centre;
      int          lap;
      bit          row_end, last_row;
      result_type  res;
      logic [COL_W-1:0] xi;
      // out-of-range sizes: zero means one, oversize means the maximum
      w = (frame_width == 0) ? 1 : ((frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width);
      h = (frame_height == 0) ? 1 : ((frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height);
      x = col_pos;
      y = row_pos;
      xi = COL_W'(x);
      gray = (int'(GRAY_WEIGHT_R) * red + int'(GRAY_WEIGHT_G) * green
              + int'(GRAY_WEIGHT_B) * blue) >> 8;
      row_end  = (x >= w - 1);
      last_row = (y >= h - 1);

      // this request completes the pixel directly above it
      if (y >= 1) begin
         centre = 32'(line_newer[xi]);
         res.edge_value = PIX_W'(centre);
         // interior only: not first/last row or column (last row handled below)
         if (y - 1 != 0 && x != 0 && x < w - 1 && x + 1 < MAX_WIDTH) begin
            lap = 4 * int'(centre) - int'(line_older[xi]) - int'(gray)
                  - int'(line_older[xi - COL_W'(1)]) - int'(line_newer[xi + COL_W'(1)]);
            if (lap < 0) lap = 0;
            if (lap > 255) lap = 255;
            res.edge_value = PIX_W'(lap);
         end
         res.pixel_column = COL_W'(x);
         res.pixel_row    = ROW_W'(y - 1);
         res.last_of_run  = !last_row;
         res.end_of_frame = 1'b0;
         pending_results.push_back(res);
      end

      // last row: the pixel itself goes straight out as a border pixel
      if (last_row) begin
         res.edge_value   = PIX_W'(gray);
         res.pixel_column = COL_W'(x);
         res.pixel_row    = ROW_W'(y);
         res.last_of_run  = 1'b1;
         res.end_of_frame = row_end;
         pending_results.push_back(res);
      end

      line_older[xi] = line_newer[xi];
      line_newer[xi] = PIX_W'(gray);

      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking. Handshakes are sampled at the falling edge, where
   // everything driven or registered at the last rising edge is settled.
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want_v, got_v);
      if (got_v !== want_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
      end else begin
         want = pending_results.pop_front();
         compare_field("edge_value", 32'(want.edge_value), 32'(rsp_tdata[COL_LSB-1:0]));
         compare_field("pixel_column", 32'(want.pixel_column),
                       32'(rsp_tdata[ROW_LSB-1:COL_LSB]));
         compare_field("pixel_row", 32'(want.pixel_row), 32'(rsp_tdata[PAD_LSB-1:ROW_LSB]));
         compare_field("tdata padding", 32'(0), 32'(rsp_tdata[RSP_DATA_W-1:PAD_LSB]));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_tlast));
         compare_field("end_of_frame", 32'(want.end_of_frame), 32'(rsp_tuser));
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
   end

   // result side: random stalls, a steady window, and long hold-offs on request
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 15);
      end
   end

   // watchdog: nothing moving on either side for too long
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request side helpers. All of them are entered and left at a rising edge.
   // ---------------------------------------------------------------------

   // offer one pixel, with optional idle cycles ahead of it; tvalid is left
   // high so back-to-back requests need no extra assignment
   task automatic send_pixel(input logic [PIX_W-1:0] red, green, blue);
      bit taken;
      if (!steady_flow) begin
         while ($urandom_range(99) < 15) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      predict_pixel(red, green, blue);
   endtask

   // mostly uniform, with a bias to black and white so both clamps get hit
   function automatic logic [PIX_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_pixel();
      send_pixel(random_channel(), random_channel(), random_channel());
   endtask

   // stop offering, wait for every owed result, then let the pipe go quiet
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sizes are only ever changed with the block idle
   task automatic set_frame_size(input logic [DIM_W-1:0] width_value, height_value);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_IMAGE_WIDTH;
      csr_wr_data <= width_value;
      @(posedge clock);
      frame_width  = width_value;
      csr_index   <= REG_IMAGE_HEIGHT;
      csr_wr_data <= height_value;
      @(posedge clock);
      frame_height = height_value;
      csr_wr_en   <= 1'b0;
   endtask

   task automatic pick_random_size();
      logic [DIM_W-1:0] w, h;
      w = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(13, 64))
                                   : DIM_W'($urandom_range(0, 12));
      h = DIM_W'($urandom_range(0, 8));
      set_frame_size(w, h);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset sizes (1024 wide, 1024 high): a partial first row gives no
   // results. The size is then cut to 16x2 mid-frame, so the next request
   // ends the first row and the second row becomes the last one.
   task automatic test_default_size();
      repeat (24) send_random_pixel();
      set_frame_size(11'd16, 11'd2);
      repeat (17) send_random_pixel();
   endtask

   // 4x3 frame with hard contrast: a white centre saturates high, a black
   // centre with white around it saturates at zero
   task automatic test_clamp_extremes();
      logic [23:0] pattern [12];
      pattern = '{24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                  24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                  24'hFFFFFF, 24'hFFFFFF, 24'h808080, 24'h7F7F7F};
      set_frame_size(11'd4, 11'd3);
      foreach (pattern[i])
         send_pixel(pattern[i][23:16], pattern[i][15:8], pattern[i][7:0]);
   endtask

   // zero sizes count as one: every request is its own one-pixel frame
   task automatic test_zero_sizes();
      set_frame_size(11'd0, 11'd0);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_random_pixel();
   endtask

   // below three columns every pixel is on the border
   task automatic test_narrow_frame();
      set_frame_size(11'd2, 11'd3);
      repeat (6) send_random_pixel();
   endtask

   // oversize width clamps to 1024; single row, so one result per request
   // and no early row end. Run with no idling on either side, then the
   // width is cut under the counter so the next request ends the frame.
   task automatic test_oversize_row();
      set_frame_size(11'd2047, 11'd1);
      steady_flow = 1'b1;
      repeat (64) send_random_pixel();
      steady_flow = 1'b0;
      set_frame_size(11'd65, 11'd1);
      send_random_pixel();
   endtask

   // one column, oversize height clamped to 1024; the height is then cut
   // under the row counter so the next request is on the last row
   task automatic test_tall_column();
      set_frame_size(11'd1, 11'd2047);
      repeat (48) send_random_pixel();
      set_frame_size(11'd1, 11'd49);
      send_random_pixel();
   endtask

   // sizes shrunk under the running counters: at (3,2) the new width ends
   // the row and the new height ends the frame on the same request
   task automatic test_mid_frame_resize();
      set_frame_size(11'd6, 11'd5);
      repeat (15) send_random_pixel();
      set_frame_size(11'd4, 11'd3);
      send_random_pixel();
      repeat (12) send_random_pixel();
   endtask

   // result side held off for a long stretch while a last row floods the
   // queue: the block has to stall its requests
   task automatic test_output_stall();
      set_frame_size(11'd16, 11'd2);
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (32) send_random_pixel();
   endtask

   // sender stops mid-frame until everything owed has come back
   task automatic test_sender_pause();
      set_frame_size(11'd7, 11'd5);
      repeat (17) send_random_pixel();
      wait_until_drained();
      repeat (18) send_random_pixel();
   endtask

   // whole frames of small random size, resized only between frames; one
   // window with no idling on either side
   task automatic test_random_frames();
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS || col_pos != 0 || row_pos != 0) begin
         if (col_pos == 0 && row_pos == 0 && $urandom_range(2) == 0)
            pick_random_size();
         steady_flow = (sent >= 300 && sent < 420);
         send_random_pixel();
         sent++;
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      foreach (line_older[i]) begin
         line_older[i] = '0;
         line_newer[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_size();
      test_clamp_extremes();
      test_zero_sizes();
      test_narrow_frame();
      test_oversize_row();
      test_tall_column();
      test_mid_frame_resize();
      test_output_stall();
      test_sender_pause();
      test_random_frames();

      wait_until_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/glef_pkg.sv
rtl/glef_ram.sv
rtl/gray_laplacian_edge_filter.sv
rtl/glef_checker.sv
tb/tb_gray_laplacian_edge_filter.sv
